/* rtl/hsv_gradient_row_color_assert.svh */
// ----------------------------------------------------------------------------
// hsv_gradient_row_color assertion macros
// Shorthand for the concurrent checks of the row color pipeline.
// ----------------------------------------------------------------------------
`ifndef HSV_GRADIENT_ROW_COLOR_ASSERT_SVH
`define HSV_GRADIENT_ROW_COLOR_ASSERT_SVH

// same-cycle implication, held off during reset
`define HGRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgrc: implication check failed");

// next-cycle implication, held off during reset
`define HGRC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgrc: next-cycle check failed");

`endif

/* rtl/hgrc_pkg.sv */
// ----------------------------------------------------------------------------
// hgrc_pkg
// Shared types and constants of the hue gradient row color pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hgrc_pkg;

  // field widths
  localparam int ROW_W      = 7;
  localparam int ROW_SPAN   = 2 ** ROW_W;
  localparam int HUE_W      = 12;
  localparam int LVL_W      = 8;
  localparam int FRAC_W     = 10;
  localparam int MAG_W      = 22;
  localparam int WITHIN_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // pipeline split
  localparam int HUE_STAGES = 4;
  localparam int HSV_STAGES = 6;
  localparam int PIPE_DEPTH = HUE_STAGES + HSV_STAGES;

  // arithmetic constants
  localparam int FRAC_SCALE  = 1000;
  localparam int HUE_SECTOR  = 600;
  localparam int NUM_SECTORS = 6;
  localparam int LVL_MAX     = 255;

  // exact reciprocals: floor(x * K / 2**S) == floor(x / d) over the operand range
  localparam int unsigned RECIP_1000    = 4294968;  // x < 2**22
  localparam int          RECIP_1000_SH = 32;
  localparam int unsigned RECIP_600     = 447393;   // x < 2**18
  localparam int          RECIP_600_SH  = 28;
  localparam int unsigned RECIP_255     = 65794;    // x < 2**16
  localparam int          RECIP_255_SH  = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HUE_START  = 2'd0,
    CFG_HUE_END    = 2'd1,
    CFG_SATURATION = 2'd2,
    CFG_BRIGHTNESS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_e;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] vld;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

/* rtl/hgrc_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// hgrc_pipe_ctrl
// Valid bits and per-stage load enables; bubbles collapse under a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgrc_pipe_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_ready_i,
  output logic                 in_ready_o,
  output hgrc_pkg::pipe_ctrl_t ctrl_o
);
  import hgrc_pkg::*;

  logic [PIPE_DEPTH-1:0] vld_q, vld_d;
  logic [PIPE_DEPTH:0]   rdy;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[PIPE_DEPTH] = out_ready_i;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (rdy[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctrl_o.en  = rdy[PIPE_DEPTH-1:0];
  assign ctrl_o.vld = vld_q;

endmodule

`default_nettype wire

/* rtl/hgrc_hue_pipe.sv */
// ----------------------------------------------------------------------------
// hgrc_hue_pipe
// Row to hue: fraction lookup, span multiply, divide by 1000, offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgrc_hue_pipe #(
  parameter int ROWS = 108
) (
  input  logic                             clk_i,
  input  logic [hgrc_pkg::HUE_STAGES-1:0]  en_i,
  input  logic [hgrc_pkg::ROW_W-1:0]       row_index_i,
  input  logic [hgrc_pkg::HUE_W-1:0]       hue_start_i,
  input  logic [hgrc_pkg::HUE_W-1:0]       hue_end_i,
  output logic [hgrc_pkg::HUE_W-1:0]       hue_o
);
  import hgrc_pkg::*;

  localparam int ProdW = HUE_W + 1 + FRAC_W + 1;
  localparam int QuoPW = MAG_W + 23;

  logic [FRAC_W-1:0] frac_lut [ROW_SPAN];

  // rows past the area clamp to the last row; all folded at elaboration
  for (genvar k = 0; k < ROW_SPAN; k++) begin : g_frac
    localparam int RowC = (k < ROWS) ? k : ROWS - 1;
    assign frac_lut[k] = FRAC_W'((RowC * FRAC_SCALE) / ROWS);
  end

  // stage 1: fraction in thousandths
  logic [FRAC_W-1:0] frac_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      frac_q <= frac_lut[row_index_i];
    end
  end

  // stage 2: magnitude and sign of span * frac
  logic signed [HUE_W:0]   span_s;
  logic signed [ProdW-1:0] prod_s;
  logic [ProdW-1:0]        prod_abs;
  logic [MAG_W-1:0]        mag_q, mag_d;
  logic                    neg2_q;

  always_comb begin
    span_s   = $signed({1'b0, hue_end_i}) - $signed({1'b0, hue_start_i});
    prod_s   = $signed({{(ProdW - HUE_W - 1){span_s[HUE_W]}}, span_s}) *
               $signed({{(ProdW - FRAC_W){1'b0}}, frac_q});
    prod_abs = prod_s[ProdW-1] ? ProdW'(-prod_s) : ProdW'(prod_s);
    mag_d    = prod_abs[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mag_q  <= mag_d;
      neg2_q <= prod_s[ProdW-1];
    end
  end

  // stage 3: truncating divide by 1000 through the reciprocal
  logic [QuoPW-1:0] quo_prod;
  logic [HUE_W-1:0] quo_q;
  logic             neg3_q;

  assign quo_prod = QuoPW'(mag_q) * QuoPW'(RECIP_1000);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      quo_q  <= quo_prod[RECIP_1000_SH +: HUE_W];
      neg3_q <= neg2_q;
    end
  end

  // stage 4: offset from the start hue, floored at zero
  logic [HUE_W:0]   hue_sum;
  logic [HUE_W-1:0] hue_q, hue_d;

  always_comb begin
    hue_sum = neg3_q ? ({1'b0, hue_start_i} - {1'b0, quo_q})
                     : ({1'b0, hue_start_i} + {1'b0, quo_q});
    hue_d   = (neg3_q && hue_sum[HUE_W]) ? '0 : hue_sum[HUE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hue_q <= hue_d;
    end
  end

  assign hue_o = hue_q;

endmodule

`default_nettype wire

/* rtl/hgrc_hsv_pipe.sv */
// ----------------------------------------------------------------------------
// hgrc_hsv_pipe
// Integer HSV to RGB: sector split, p/q/t products and reciprocal divides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hgrc_hsv_pipe (
  input  logic                             clk_i,
  input  logic [hgrc_pkg::HSV_STAGES-1:0]  en_i,
  input  logic [hgrc_pkg::HUE_W-1:0]       hue_i,
  input  logic [hgrc_pkg::LVL_W-1:0]       sat_i,
  input  logic [hgrc_pkg::LVL_W-1:0]       val_i,
  output logic [3*hgrc_pkg::LVL_W-1:0]     rgb888_o,
  output logic [15:0]                      rgb565_o
);
  import hgrc_pkg::*;

  localparam int NumW  = 2 * LVL_W;
  localparam int SwW   = LVL_W + WITHIN_W;
  localparam int DivAW = SwW + 19;
  localparam int DivBW = NumW + 17;

  // stage 5: sector and position within it
  logic [2:0]          sec_cnt;
  logic [HUE_W-1:0]    sec_base;
  sector_e             sec5_q, sec5_d;
  logic [WITHIN_W-1:0] within_q;

  always_comb begin
    sec_cnt = '0;
    for (int k = 1; k <= NUM_SECTORS; k++) begin
      sec_cnt = sec_cnt + 3'(hue_i >= HUE_W'(k * HUE_SECTOR));
    end
    sec_base = HUE_W'(sec_cnt) * HUE_W'(HUE_SECTOR);
    // hues of 3600 and up wrap into the red sector
    sec5_d = (sec_cnt == 3'(NUM_SECTORS)) ? SEC_RED : sector_e'(sec_cnt);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sec5_q   <= sec5_d;
      within_q <= WITHIN_W'(hue_i - sec_base);
    end
  end

  // stage 6: saturation products
  logic [SwW-1:0]  sw_q, sr_q;
  logic [NumW-1:0] pn6_q;
  sector_e         sec6_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      sw_q   <= SwW'(sat_i) * SwW'(within_q);
      sr_q   <= SwW'(sat_i) * SwW'(WITHIN_W'(HUE_SECTOR) - within_q);
      pn6_q  <= NumW'(val_i) * NumW'(LVL_W'(LVL_MAX) - sat_i);
      sec6_q <= sec5_q;
    end
  end

  // stage 7: divide by 600
  logic [DivAW-1:0] da_prod, db_prod;
  logic [LVL_W-1:0] a_q, b_q;
  logic [NumW-1:0]  pn7_q;
  sector_e          sec7_q;

  assign da_prod = DivAW'(sw_q) * DivAW'(RECIP_600);
  assign db_prod = DivAW'(sr_q) * DivAW'(RECIP_600);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      a_q    <= da_prod[RECIP_600_SH +: LVL_W];
      b_q    <= db_prod[RECIP_600_SH +: LVL_W];
      pn7_q  <= pn6_q;
      sec7_q <= sec6_q;
    end
  end

  // stage 8: value products for q and t
  logic [NumW-1:0] qn_q, tn_q, pn8_q;
  sector_e         sec8_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      qn_q   <= NumW'(val_i) * NumW'(LVL_W'(LVL_MAX) - a_q);
      tn_q   <= NumW'(val_i) * NumW'(LVL_W'(LVL_MAX) - b_q);
      pn8_q  <= pn7_q;
      sec8_q <= sec7_q;
    end
  end

  // stage 9: divide by 255
  logic [DivBW-1:0] dp_prod, dq_prod, dt_prod;
  logic [LVL_W-1:0] p_q, q_q, t_q;
  sector_e          sec9_q;

  assign dp_prod = DivBW'(pn8_q) * DivBW'(RECIP_255);
  assign dq_prod = DivBW'(qn_q) * DivBW'(RECIP_255);
  assign dt_prod = DivBW'(tn_q) * DivBW'(RECIP_255);

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      p_q    <= dp_prod[RECIP_255_SH +: LVL_W];
      q_q    <= dq_prod[RECIP_255_SH +: LVL_W];
      t_q    <= dt_prod[RECIP_255_SH +: LVL_W];
      sec9_q <= sec8_q;
    end
  end

  // stage 10: channel select and output register
  logic [LVL_W-1:0]       r_d, g_d, b_d;
  logic [3*LVL_W-1:0]     rgb888_q;
  logic [15:0]            rgb565_q;

  always_comb begin
    unique case (sec9_q)
      SEC_RED: begin
        r_d = val_i; g_d = t_q; b_d = p_q;
      end
      SEC_YELLOW: begin
        r_d = q_q; g_d = val_i; b_d = p_q;
      end
      SEC_GREEN: begin
        r_d = p_q; g_d = val_i; b_d = t_q;
      end
      SEC_CYAN: begin
        r_d = p_q; g_d = q_q; b_d = val_i;
      end
      SEC_BLUE: begin
        r_d = t_q; g_d = p_q; b_d = val_i;
      end
      default: begin
        r_d = val_i; g_d = p_q; b_d = q_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      rgb888_q <= {r_d, g_d, b_d};
      rgb565_q <= {r_d[7:3], g_d[7:2], b_d[7:3]};
    end
  end

  assign rgb888_o = rgb888_q;
  assign rgb565_o = rgb565_q;

endmodule

`default_nettype wire

/* rtl/hsv_gradient_row_color.sv */
// ----------------------------------------------------------------------------
// hsv_gradient_row_color
// Row color of a vertical hue gradient, given as RGB888 and RGB565.
// ----------------------------------------------------------------------------
// One row index enters per clock while the output is not stalled, and its
// color passes through ten register stages (four for the hue ramp, six for
// the HSV conversion, the last one being the output register), each for one
// lookup, product, divide, add, compare or select step. A stalled output
// fills the empty stages first before the input side holds off. Register
// writes are expected while no row is in flight. The block holds no other
// state, and there is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "hsv_gradient_row_color_assert.svh"

module hsv_gradient_row_color #(
  parameter int ROWS = 108
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hgrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [hgrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // row input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [hgrc_pkg::ROW_W-1:0]        row_index_i,
  // color output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [23:0]                       color_rgb888_o,
  output logic [15:0]                       color_rgb565_o
);
  import hgrc_pkg::*;

  // configuration registers
  logic [HUE_W-1:0] hue_start_q, hue_end_q;
  logic [LVL_W-1:0] saturation_q, brightness_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_start_q  <= HUE_W'(0);
      hue_end_q    <= HUE_W'(1800);
      saturation_q <= LVL_W'(LVL_MAX);
      brightness_q <= LVL_W'(LVL_MAX);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HUE_START:  hue_start_q  <= cfg_data_i[HUE_W-1:0];
        CFG_HUE_END:    hue_end_q    <= cfg_data_i[HUE_W-1:0];
        CFG_SATURATION: saturation_q <= cfg_data_i[LVL_W-1:0];
        CFG_BRIGHTNESS: brightness_q <= cfg_data_i[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  pipe_ctrl_t ctrl;

  hgrc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .in_ready_o  (in_ready_o),
    .ctrl_o      (ctrl)
  );

  logic [HUE_W-1:0] hue;

  hgrc_hue_pipe #(
    .ROWS (ROWS)
  ) u_hue (
    .clk_i       (clk_i),
    .en_i        (ctrl.en[HUE_STAGES-1:0]),
    .row_index_i (row_index_i),
    .hue_start_i (hue_start_q),
    .hue_end_i   (hue_end_q),
    .hue_o       (hue)
  );

  hgrc_hsv_pipe u_hsv (
    .clk_i    (clk_i),
    .en_i     (ctrl.en[PIPE_DEPTH-1:HUE_STAGES]),
    .hue_i    (hue),
    .sat_i    (saturation_q),
    .val_i    (brightness_q),
    .rgb888_o (color_rgb888_o),
    .rgb565_o (color_rgb565_o)
  );

  assign out_valid_o = ctrl.vld[PIPE_DEPTH-1];

  // a ready sink keeps the whole pipeline moving
  `HGRC_ASSERT_IMP(a_ready_flows, clk_i, rst_ni, out_ready_i, in_ready_o)
  // input back-pressure only when every stage holds a transaction
  `HGRC_ASSERT_IMP(a_full_on_stall, clk_i, rst_ni, !in_ready_o, &ctrl.vld)
  // an accepted transaction lands in the first stage
  `HGRC_ASSERT_NXT(a_enter_stage, clk_i, rst_ni, in_valid_i && in_ready_o, ctrl.vld[0])

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// hsv_gradient_row_color testbench
// Sends row indices under a sweep of hue ramps, saturations and brightness
// levels, with random idle bursts on both channels. Each color that leaves
// the block is checked against an in-bench prediction of the gradient and
// the HSV conversion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hgrc_pkg::*;

  localparam int ROWS         = 108;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;

  typedef struct packed {
    logic [23:0] rgb888;
    logic [15:0] rgb565;
  } row_color_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ROW_W-1:0]      row_index_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [23:0]           color_rgb888_o;
  logic [15:0]           color_rgb565_o;

  // register copies as the block should hold them
  logic [HUE_W-1:0] hue_start_q;
  logic [HUE_W-1:0] hue_end_q;
  logic [LVL_W-1:0] saturation_q;
  logic [LVL_W-1:0] brightness_q;

  row_color_t pending_colors[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         sender_idles = 1'b0;
  bit         receiver_stalls = 1'b0;
  int         stall_left = 0;

  hsv_gradient_row_color #(
    .ROWS(ROWS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .row_index_i   (row_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .color_rgb888_o(color_rgb888_o),
    .color_rgb565_o(color_rgb565_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsv_gradient_row_color test failed");
      $finish;
    end
  end

  // color of one row under the current register copies
  function automatic row_color_t gradient_color(logic [ROW_W-1:0] row);
    int         r, frac, span, hue, sector, hue_pos, sat, val, p, q, t;
    logic [7:0] red, green, blue;
    row_color_t c;
    r = row;
    if (r >= ROWS) r = ROWS - 1;
    frac = (r * FRAC_SCALE) / ROWS;
    span = int'(hue_end_q) - int'(hue_start_q);
    hue = int'(hue_start_q) + (span * frac) / FRAC_SCALE;
    if (hue < 0) hue = 0;
    sector = (hue / HUE_SECTOR) % NUM_SECTORS;
    hue_pos = hue % HUE_SECTOR;
    sat = saturation_q;
    val = brightness_q;
    p = val * (LVL_MAX - sat) / LVL_MAX;
    q = val * (LVL_MAX - (sat * hue_pos) / HUE_SECTOR) / LVL_MAX;
    t = val * (LVL_MAX - (sat * (HUE_SECTOR - hue_pos)) / HUE_SECTOR) / LVL_MAX;
    case (sector_e'(sector[2:0]))
      SEC_RED: begin
        red = 8'(val); green = 8'(t); blue = 8'(p);
      end
      SEC_YELLOW: begin
        red = 8'(q); green = 8'(val); blue = 8'(p);
      end
      SEC_GREEN: begin
        red = 8'(p); green = 8'(val); blue = 8'(t);
      end
      SEC_CYAN: begin
        red = 8'(p); green = 8'(q); blue = 8'(val);
      end
      SEC_BLUE: begin
        red = 8'(t); green = 8'(p); blue = 8'(val);
      end
      default: begin
        red = 8'(val); green = 8'(p); blue = 8'(q);
      end
    endcase
    c.rgb888 = {red, green, blue};
    c.rgb565 = {red[7:3], green[7:2], blue[7:3]};
    return c;
  endfunction

  // all sampling happens here, on pre-edge values
  always @(posedge clk_i) begin
    row_color_t exp_c;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) pending_colors.push_back(gradient_color(row_index_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HUE_START:  hue_start_q  <= cfg_data_i[HUE_W-1:0];
          CFG_HUE_END:    hue_end_q    <= cfg_data_i[HUE_W-1:0];
          CFG_SATURATION: saturation_q <= cfg_data_i[LVL_W-1:0];
          CFG_BRIGHTNESS: brightness_q <= cfg_data_i[LVL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_colors.size() == 0) begin
          mismatch_count++;
          $display("%0t: color with none expected, actual rgb888 %06h rgb565 %04h",
                   $time, color_rgb888_o, color_rgb565_o);
        end else begin
          exp_c = pending_colors.pop_front();
          if (color_rgb888_o !== exp_c.rgb888) begin
            mismatch_count++;
            $display("%0t: rgb888 mismatch, expected %06h, actual %06h",
                     $time, exp_c.rgb888, color_rgb888_o);
          end
          if (color_rgb565_o !== exp_c.rgb565) begin
            mismatch_count++;
            $display("%0t: rgb565 mismatch, expected %04h, actual %04h",
                     $time, exp_c.rgb565, color_rgb565_o);
          end
        end
      end
    end
  end

  // output back-pressure in random bursts
  always @(posedge clk_i) begin
    if (!receiver_stalls) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_row(logic [ROW_W-1:0] row);
    int gap;
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_index_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // let every row in flight come out before touching registers
  task automatic drain_rows();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_gradient(logic [CFG_DATA_W-1:0] hs, logic [CFG_DATA_W-1:0] he,
                              logic [CFG_DATA_W-1:0] sat, logic [CFG_DATA_W-1:0] br);
    drain_rows();
    write_reg(CFG_HUE_START, hs);
    write_reg(CFG_HUE_END, he);
    write_reg(CFG_SATURATION, sat);
    write_reg(CFG_BRIGHTNESS, br);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_hue();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'(0);
      1: return CFG_DATA_W'(3599);
      2: return CFG_DATA_W'(4095);
      3: return CFG_DATA_W'($urandom_range(3600, 4095));
      default: return CFG_DATA_W'($urandom_range(0, 3599));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_level();
    case ($urandom_range(0, 5))
      0: return CFG_DATA_W'(0);
      1: return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [ROW_W-1:0] pick_row();
    if ($urandom_range(0, 5) == 0) return ROW_W'($urandom_range(ROWS, ROW_SPAN - 1));
    return ROW_W'($urandom_range(0, ROWS - 1));
  endfunction

  task automatic test_reset_defaults();
    send_row(0);
    send_row(ROWS - 1);
    send_row(ROW_SPAN - 1);
  endtask

  // end hue below the start, and a row just past the area
  task automatic test_descending_hue();
    set_gradient(3599, 0, 255, 255);
    send_row(0);
    send_row(54);
    send_row(ROWS - 1);
    send_row(ROWS);
  endtask

  // hues of 3600 and above wrap into the red region
  task automatic test_hue_wrap();
    set_gradient(4095, 3600, 'hFFF, 128);
    send_row(0);
    send_row(64);
    send_row(ROW_SPAN - 1);
  endtask

  task automatic test_gray_levels();
    set_gradient(1234, 2800, 0, 200);
    send_row(0);
    send_row(50);
    send_row(ROWS - 1);
    set_gradient(0, 3599, 255, 0);
    send_row(1);
    send_row(85);
    set_gradient(3599, 3599, 1, 'hF01);
    send_row(42);
    send_row(ROWS - 1);
  endtask

  task automatic test_random_gradients();
    for (int phase = 0; phase < 12; phase++) begin
      if (phase >= 10) begin
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
      end else begin
        sender_idles = (phase % 3) != 2;
        receiver_stalls = (phase % 4) != 3;
      end
      case (phase)
        0: set_gradient(0, 4095, 255, 255);
        1: set_gradient(4095, 0, 0, 0);
        default: set_gradient(pick_hue(), pick_hue(), pick_level(), pick_level());
      endcase
      for (int n = 0; n < 120; n++) send_row(pick_row());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    row_index_i = '0;
    out_ready_i = 1'b1;
    hue_start_q  = 12'd0;
    hue_end_q    = 12'd1800;
    saturation_q = 8'd255;
    brightness_q = 8'd255;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_descending_hue();
    test_hue_wrap();
    test_gray_levels();
    test_random_gradients();

    drain_rows();
    if (mismatch_count == 0 && pending_colors.size() == 0) begin
      $display("hsv_gradient_row_color test passed");
    end else begin
      $display("hsv_gradient_row_color test failed");
    end
    $finish;
  end

endmodule
